>>> sv/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg: shared types and constants for the Burgers Rusanov flux core
// Widths of the grid samples, the flux datapath and the sample store.
// ---------------------------------------------------------------------------
package brf_pkg;

    // Grid store geometry.
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;

    // Sample and register widths, Q16.16.
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // Datapath widths: products, face flux in Q32.16 and flux difference.
    localparam int PROD_W = 2 * DATA_W;
    localparam int FLUX_W = PROD_W - FRAC_W;
    localparam int DIFF_W = FLUX_W + 1;
    localparam int RND_W  = PROD_W + 1 - FRAC_W;
    localparam int SUM_W  = RND_W + 1;

    localparam logic [DATA_W-1:0] INV_DX_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] POS_LIMIT    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIMIT    = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic        [DATA_W-1:0] mag_t;
    typedef logic        [PROD_W-1:0] prod_t;
    typedef logic signed [FLUX_W-1:0] flux_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    // Magnitude of a signed sample; the most negative value maps to 2^31.
    function automatic mag_t abs_sample(input sample_t v);
        mag_t r;
        r = v[DATA_W-1] ? mag_t'(-v) : mag_t'(v);
        return r;
    endfunction

endpackage

>>> sv/brf_in_if.sv
// ---------------------------------------------------------------------------
// brf_in_if: sample input channel
// Carries one grid sample and the end-of-grid mark per transfer.
// ---------------------------------------------------------------------------
interface brf_in_if
    import brf_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

>>> sv/brf_out_if.sv
// ---------------------------------------------------------------------------
// brf_out_if: derivative output channel
// Carries one saturated time derivative and its flags per transfer.
// ---------------------------------------------------------------------------
interface brf_out_if
    import brf_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t derivative;
    logic    saturated;
    logic    last_out;

    modport source (output valid, output derivative, output saturated,
                    output last_out, input ready);
    modport sink (input valid, input derivative, input saturated,
                  input last_out, output ready);
endinterface

>>> sv/brf_cfg_if.sv
// ---------------------------------------------------------------------------
// brf_cfg_if: configuration write channel
// Carries the reciprocal grid spacing, unsigned Q16.16, per transfer.
// ---------------------------------------------------------------------------
interface brf_cfg_if
    import brf_pkg::*;
;
    logic       valid;
    logic       ready;
    mag_t       inv_dx;

    modport source (output valid, output inv_dx, input ready);
    modport sink (input valid, input inv_dx, output ready);
endinterface

>>> sv/brf_mul.sv
// ---------------------------------------------------------------------------
// brf_mul: shared unsigned multiplier
// One 32x32 unsigned product per cycle, registered at the output.
// ---------------------------------------------------------------------------
module brf_mul
    import brf_pkg::*;
(
    input  logic  clk,
    input  mag_t  op_a,
    input  mag_t  op_b,
    output prod_t product
);

    prod_t product_reg;

    // Product register; the sequencer picks it up in the cycle after the operands.
    always_ff @(posedge clk)
    begin
        product_reg <= prod_t'(op_a) * prod_t'(op_b);
    end

    assign product = product_reg;

endmodule

>>> sv/burgers_rusanov_flux_rhs_core.sv
// ---------------------------------------------------------------------------
// burgers_rusanov_flux_rhs_core: Burgers right-hand side, Rusanov flux
// Loads a periodic grid one sample per transfer, then emits one time
// derivative per point from a single shared multiplier under a sequencer.
// Throughput: samples load at one per cycle. The final sample starts a pass
// over the n points, paced by the shared multiplier that forms three
// products per face and two per output scaling. No new sample is taken
// until the last derivative is loaded.
// Reset: count, maximum speed, state and output valid clear; inv_dx = 1.0.
// ---------------------------------------------------------------------------
module burgers_rusanov_flux_rhs_core
    import brf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    brf_cfg_if.sink    cfg,
    brf_in_if.sink     samples,
    brf_out_if.source  results
);

    // Sequencer state codes.
    localparam logic [4:0] ST_LOAD = 5'd0;
    localparam logic [4:0] ST_RD0  = 5'd1;
    localparam logic [4:0] ST_RDN  = 5'd2;
    localparam logic [4:0] ST_WSET = 5'd3;
    localparam logic [4:0] ST_F1   = 5'd4;
    localparam logic [4:0] ST_F2   = 5'd5;
    localparam logic [4:0] ST_F3   = 5'd6;
    localparam logic [4:0] ST_F4   = 5'd7;
    localparam logic [4:0] ST_PT   = 5'd8;
    localparam logic [4:0] ST_PTRD = 5'd9;
    localparam logic [4:0] ST_D    = 5'd10;
    localparam logic [4:0] ST_ABS  = 5'd11;
    localparam logic [4:0] ST_M1   = 5'd12;
    localparam logic [4:0] ST_M2   = 5'd13;
    localparam logic [4:0] ST_M3   = 5'd14;
    localparam logic [4:0] ST_R    = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    logic [4:0]       state_reg;
    logic [CNT_W-1:0] point_count_reg;
    mag_t             max_speed_reg;
    mag_t             inv_dx_reg;
    logic [ADDR_W-1:0] k_reg;

    // Sample store and its registered read port.
    sample_t           grid_mem [MAX_POINTS];
    sample_t           rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    // Face operands and partial results.
    sample_t first_reg;
    sample_t cur_reg;
    sample_t ua_reg;
    sample_t ub_reg;
    mag_t    speed_reg;
    mag_t    du_abs_reg;
    logic    du_neg_reg;
    logic    wrap_face_reg;
    prod_t   sq_reg;
    flux_t   wrap_flux_reg;
    flux_t   prev_flux_reg;
    flux_t   next_flux_reg;

    // Output scaling registers.
    diff_t             d_reg;
    logic [DIFF_W-1:0] m_reg;
    logic              neg_reg;
    logic              big_reg;
    logic [FRAC_W-1:0] hp_reg;
    logic [RND_W-1:0]  rnd_reg;
    sample_t           fin_val_reg;
    logic              fin_sat_reg;

    // Output register.
    logic    res_valid_reg;
    sample_t res_derivative_reg;
    logic    res_saturated_reg;
    logic    res_last_reg;

    // Shared multiplier.
    mag_t  mul_a;
    mag_t  mul_b;
    prod_t product;

    logic              in_xfer;
    logic              has_next;
    logic              last_pt;
    logic              out_free;
    logic              out_load;
    logic [33-1:0]     du_wide;
    prod_t             sq4;
    prod_t             half_mag;
    prod_t             f32;
    logic [SUM_W-1:0]  r_sum;
    logic              r_over;
    mag_t              abs_first;
    mag_t              abs_lastv;

    brf_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    assign samples.ready = (state_reg == ST_LOAD);
    assign cfg.ready     = 1'b1;
    assign in_xfer       = samples.valid && samples.ready;
    assign wr_en         = in_xfer && (point_count_reg < CNT_W'(MAX_POINTS));

    // Point bookkeeping during the pass.
    assign has_next = (CNT_W'(k_reg) + CNT_W'(1)) < point_count_reg;
    assign last_pt  = CNT_W'(k_reg) == (point_count_reg - CNT_W'(1));
    assign out_free = !res_valid_reg || results.ready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // Read address for the sample store.
    always_comb
    begin
        unique case (state_reg)
            ST_RDN:  rd_addr = point_count_reg[ADDR_W-1:0] - ADDR_W'(1);
            ST_PT:   rd_addr = k_reg + ADDR_W'(1);
            default: rd_addr = '0;
        endcase
    end

    // Sample store: written during the load, read during the pass.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[point_count_reg[ADDR_W-1:0]] <= samples.sample;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (state_reg)
            ST_F1:
            begin
                mul_a = abs_sample(ua_reg);
                mul_b = abs_sample(ua_reg);
            end
            ST_F2:
            begin
                mul_a = abs_sample(ub_reg);
                mul_b = abs_sample(ub_reg);
            end
            ST_F3:
            begin
                mul_a = du_abs_reg;
                mul_b = speed_reg;
            end
            ST_M1:
            begin
                mul_a = mag_t'(m_reg[DIFF_W-1:DATA_W]);
                mul_b = inv_dx_reg;
            end
            ST_M2:
            begin
                mul_a = m_reg[DATA_W-1:0];
                mul_b = inv_dx_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Face flux terms: the viscous half is floored toward minus infinity.
    assign du_wide   = 33'(signed'(ub_reg)) - 33'(signed'(ua_reg));
    assign sq4       = {2'b00, sq_reg[PROD_W-1:2]};
    assign half_mag  = {1'b0, product[PROD_W-1:1]};
    assign f32       = du_neg_reg ? (sq4 + half_mag + prod_t'(product[0]))
                                  : (sq4 - half_mag);
    assign abs_first = abs_sample(first_reg);
    assign abs_lastv = abs_sample(rd_data_reg);

    // Rounded scaled magnitude and its saturation test.
    assign r_sum  = SUM_W'({hp_reg, {FRAC_W{1'b0}}}) + SUM_W'(rnd_reg);
    assign r_over = neg_reg ? (r_sum > SUM_W'(NEG_LIMIT)) : (r_sum > SUM_W'(POS_LIMIT));

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_dx_reg <= INV_DX_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            inv_dx_reg <= cfg.inv_dx;
        end
    end

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            point_count_reg <= '0;
            max_speed_reg   <= '0;
            k_reg           <= '0;
            wrap_face_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (wr_en)
                    begin
                        point_count_reg <= point_count_reg + CNT_W'(1);
                        if (abs_sample(samples.sample) > max_speed_reg)
                        begin
                            max_speed_reg <= abs_sample(samples.sample);
                        end
                    end
                    if (in_xfer && samples.last)
                    begin
                        state_reg <= ST_RD0;
                    end
                end
                ST_RD0:  state_reg <= ST_RDN;
                ST_RDN:  state_reg <= ST_WSET;
                ST_WSET:
                begin
                    wrap_face_reg <= 1'b1;
                    state_reg     <= ST_F1;
                end
                ST_F1:   state_reg <= ST_F2;
                ST_F2:   state_reg <= ST_F3;
                ST_F3:   state_reg <= ST_F4;
                ST_F4:
                begin
                    if (wrap_face_reg)
                    begin
                        wrap_face_reg <= 1'b0;
                        k_reg         <= '0;
                        state_reg     <= ST_PT;
                    end
                    else
                    begin
                        state_reg <= ST_D;
                    end
                end
                ST_PT:   state_reg <= has_next ? ST_PTRD : ST_D;
                ST_PTRD: state_reg <= ST_F1;
                ST_D:    state_reg <= ST_ABS;
                ST_ABS:  state_reg <= ST_M1;
                ST_M1:   state_reg <= ST_M2;
                ST_M2:   state_reg <= ST_M3;
                ST_M3:   state_reg <= ST_R;
                ST_R:    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        k_reg <= k_reg + ADDR_W'(1);
                        if (last_pt)
                        begin
                            point_count_reg <= '0;
                            max_speed_reg   <= '0;
                            state_reg       <= ST_LOAD;
                        end
                        else
                        begin
                            state_reg <= ST_PT;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // Datapath registers, loaded by the sequencer state.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_RDN:
            begin
                first_reg <= rd_data_reg;
            end
            ST_WSET:
            begin
                ua_reg    <= rd_data_reg;
                ub_reg    <= first_reg;
                cur_reg   <= first_reg;
                speed_reg <= (abs_first > abs_lastv) ? abs_first : abs_lastv;
            end
            ST_F1:
            begin
                du_neg_reg <= du_wide[32];
                du_abs_reg <= du_wide[32] ? DATA_W'(-du_wide) : du_wide[DATA_W-1:0];
            end
            ST_F2:
            begin
                sq_reg <= product;
            end
            ST_F3:
            begin
                sq_reg <= sq_reg + product;
            end
            ST_F4:
            begin
                if (wrap_face_reg)
                begin
                    wrap_flux_reg <= flux_t'(f32[PROD_W-1:FRAC_W]);
                    prev_flux_reg <= flux_t'(f32[PROD_W-1:FRAC_W]);
                end
                else
                begin
                    next_flux_reg <= flux_t'(f32[PROD_W-1:FRAC_W]);
                end
            end
            ST_PT:
            begin
                if (!has_next)
                begin
                    next_flux_reg <= wrap_flux_reg;
                end
            end
            ST_PTRD:
            begin
                ua_reg    <= cur_reg;
                ub_reg    <= rd_data_reg;
                cur_reg   <= rd_data_reg;
                speed_reg <= max_speed_reg;
            end
            ST_D:
            begin
                d_reg <= DIFF_W'(prev_flux_reg) - DIFF_W'(next_flux_reg);
            end
            ST_ABS:
            begin
                neg_reg <= d_reg[DIFF_W-1];
                m_reg   <= d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
            end
            ST_M2:
            begin
                big_reg <= |product[PROD_W-1:FRAC_W];
                hp_reg  <= product[FRAC_W-1:0];
            end
            ST_M3:
            begin
                rnd_reg <= RND_W'(((PROD_W+1)'(product) + (PROD_W+1)'(32'h8000)) >> FRAC_W);
            end
            ST_R:
            begin
                fin_sat_reg <= big_reg || r_over;
                if (big_reg || r_over)
                begin
                    fin_val_reg <= neg_reg ? NEG_LIMIT : POS_LIMIT;
                end
                else
                begin
                    fin_val_reg <= neg_reg ? sample_t'(-r_sum[DATA_W-1:0])
                                           : sample_t'(r_sum[DATA_W-1:0]);
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    prev_flux_reg <= next_flux_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_derivative_reg <= fin_val_reg;
            res_saturated_reg  <= fin_sat_reg;
            res_last_reg       <= last_pt;
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.derivative = res_derivative_reg;
    assign results.saturated  = res_saturated_reg;
    assign results.last_out   = res_last_reg;

    // The store never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        point_count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds store depth");

    // The final sample closes the load: no sample is taken in the next cycle.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && samples.last) |=> !samples.ready)
        else $error("sample taken after the final sample");

    // Loading the final point's derivative clears the grid bookkeeping.
    a_pass_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_pt) |=> (point_count_reg == '0 && max_speed_reg == '0))
        else $error("grid state not cleared after the pass");

    // A clipped derivative holds one of the two limits.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.saturated) |->
            (results.derivative == POS_LIMIT || results.derivative == NEG_LIMIT))
        else $error("saturated derivative is not a limit value");

endmodule
